// ===== src/wsdq_pkg.sv =====
// Shared types, constants and the base step table of the wavelet subband quantizer.
// Used by every module of the block; depends on nothing.
package wsdq_pkg;

  localparam int CFG_DIM_W = 13;
  localparam int LVL_W     = 4;
  localparam int QUAL_W    = 7;
  localparam int BASE_W    = 22;
  localparam int QUO_W     = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic [2:0] REG_WIDTH     = 3'd0;
  localparam logic [2:0] REG_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_LEVELS    = 3'd2;
  localparam logic [2:0] REG_QUALITY   = 3'd3;
  localparam logic [2:0] REG_DIRECTION = 3'd4;

  localparam logic DIR_QUANTIZE   = 1'b0;
  localparam logic DIR_DEQUANTIZE = 1'b1;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] width;
    logic [CFG_DIM_W-1:0] height;
    logic [LVL_W-1:0]     levels;
    logic [QUAL_W-1:0]    quality;
    logic                 dir;
  } cfg_t;

  typedef struct packed {
    logic              dir;
    logic              zero;
    logic              neg;
    logic [31:0]       mag;
    logic [LVL_W-1:0]  shift;
    logic [LVL_W-1:0]  level;
    logic [BASE_W-1:0] base;
  } item_t;

  // Q6.16 base step for a quality setting, rounded half up.
  function automatic logic [BASE_W-1:0] quality_step(input logic [QUAL_W-1:0] q);
    logic [QUAL_W-1:0] qc;
    logic [BASE_W-1:0] b;
    qc = q;
    if (q == '0) qc = 7'd1;
    if (q > 7'd99) qc = 7'd99;
    case (qc)
      7'd1:  b = 22'((3276800 + 1 / 2) / 1);
      7'd2:  b = 22'((3276800 + 2 / 2) / 2);
      7'd3:  b = 22'((3276800 + 3 / 2) / 3);
      7'd4:  b = 22'((3276800 + 4 / 2) / 4);
      7'd5:  b = 22'((3276800 + 5 / 2) / 5);
      7'd6:  b = 22'((3276800 + 6 / 2) / 6);
      7'd7:  b = 22'((3276800 + 7 / 2) / 7);
      7'd8:  b = 22'((3276800 + 8 / 2) / 8);
      7'd9:  b = 22'((3276800 + 9 / 2) / 9);
      7'd10: b = 22'((3276800 + 10 / 2) / 10);
      7'd11: b = 22'((3276800 + 11 / 2) / 11);
      7'd12: b = 22'((3276800 + 12 / 2) / 12);
      7'd13: b = 22'((3276800 + 13 / 2) / 13);
      7'd14: b = 22'((3276800 + 14 / 2) / 14);
      7'd15: b = 22'((3276800 + 15 / 2) / 15);
      7'd16: b = 22'((3276800 + 16 / 2) / 16);
      7'd17: b = 22'((3276800 + 17 / 2) / 17);
      7'd18: b = 22'((3276800 + 18 / 2) / 18);
      7'd19: b = 22'((3276800 + 19 / 2) / 19);
      7'd20: b = 22'((3276800 + 20 / 2) / 20);
      7'd21: b = 22'((3276800 + 21 / 2) / 21);
      7'd22: b = 22'((3276800 + 22 / 2) / 22);
      7'd23: b = 22'((3276800 + 23 / 2) / 23);
      7'd24: b = 22'((3276800 + 24 / 2) / 24);
      7'd25: b = 22'((3276800 + 25 / 2) / 25);
      7'd26: b = 22'((3276800 + 26 / 2) / 26);
      7'd27: b = 22'((3276800 + 27 / 2) / 27);
      7'd28: b = 22'((3276800 + 28 / 2) / 28);
      7'd29: b = 22'((3276800 + 29 / 2) / 29);
      7'd30: b = 22'((3276800 + 30 / 2) / 30);
      7'd31: b = 22'((3276800 + 31 / 2) / 31);
      7'd32: b = 22'((3276800 + 32 / 2) / 32);
      7'd33: b = 22'((3276800 + 33 / 2) / 33);
      7'd34: b = 22'((3276800 + 34 / 2) / 34);
      7'd35: b = 22'((3276800 + 35 / 2) / 35);
      7'd36: b = 22'((3276800 + 36 / 2) / 36);
      7'd37: b = 22'((3276800 + 37 / 2) / 37);
      7'd38: b = 22'((3276800 + 38 / 2) / 38);
      7'd39: b = 22'((3276800 + 39 / 2) / 39);
      7'd40: b = 22'((3276800 + 40 / 2) / 40);
      7'd41: b = 22'((3276800 + 41 / 2) / 41);
      7'd42: b = 22'((3276800 + 42 / 2) / 42);
      7'd43: b = 22'((3276800 + 43 / 2) / 43);
      7'd44: b = 22'((3276800 + 44 / 2) / 44);
      7'd45: b = 22'((3276800 + 45 / 2) / 45);
      7'd46: b = 22'((3276800 + 46 / 2) / 46);
      7'd47: b = 22'((3276800 + 47 / 2) / 47);
      7'd48: b = 22'((3276800 + 48 / 2) / 48);
      7'd49: b = 22'((3276800 + 49 / 2) / 49);
      7'd50: b = 22'(((200 - 2 * 50) * 65536 + 50) / 100);
      7'd51: b = 22'(((200 - 2 * 51) * 65536 + 50) / 100);
      7'd52: b = 22'(((200 - 2 * 52) * 65536 + 50) / 100);
      7'd53: b = 22'(((200 - 2 * 53) * 65536 + 50) / 100);
      7'd54: b = 22'(((200 - 2 * 54) * 65536 + 50) / 100);
      7'd55: b = 22'(((200 - 2 * 55) * 65536 + 50) / 100);
      7'd56: b = 22'(((200 - 2 * 56) * 65536 + 50) / 100);
      7'd57: b = 22'(((200 - 2 * 57) * 65536 + 50) / 100);
      7'd58: b = 22'(((200 - 2 * 58) * 65536 + 50) / 100);
      7'd59: b = 22'(((200 - 2 * 59) * 65536 + 50) / 100);
      7'd60: b = 22'(((200 - 2 * 60) * 65536 + 50) / 100);
      7'd61: b = 22'(((200 - 2 * 61) * 65536 + 50) / 100);
      7'd62: b = 22'(((200 - 2 * 62) * 65536 + 50) / 100);
      7'd63: b = 22'(((200 - 2 * 63) * 65536 + 50) / 100);
      7'd64: b = 22'(((200 - 2 * 64) * 65536 + 50) / 100);
      7'd65: b = 22'(((200 - 2 * 65) * 65536 + 50) / 100);
      7'd66: b = 22'(((200 - 2 * 66) * 65536 + 50) / 100);
      7'd67: b = 22'(((200 - 2 * 67) * 65536 + 50) / 100);
      7'd68: b = 22'(((200 - 2 * 68) * 65536 + 50) / 100);
      7'd69: b = 22'(((200 - 2 * 69) * 65536 + 50) / 100);
      7'd70: b = 22'(((200 - 2 * 70) * 65536 + 50) / 100);
      7'd71: b = 22'(((200 - 2 * 71) * 65536 + 50) / 100);
      7'd72: b = 22'(((200 - 2 * 72) * 65536 + 50) / 100);
      7'd73: b = 22'(((200 - 2 * 73) * 65536 + 50) / 100);
      7'd74: b = 22'(((200 - 2 * 74) * 65536 + 50) / 100);
      7'd75: b = 22'(((200 - 2 * 75) * 65536 + 50) / 100);
      7'd76: b = 22'(((200 - 2 * 76) * 65536 + 50) / 100);
      7'd77: b = 22'(((200 - 2 * 77) * 65536 + 50) / 100);
      7'd78: b = 22'(((200 - 2 * 78) * 65536 + 50) / 100);
      7'd79: b = 22'(((200 - 2 * 79) * 65536 + 50) / 100);
      7'd80: b = 22'(((200 - 2 * 80) * 65536 + 50) / 100);
      7'd81: b = 22'(((200 - 2 * 81) * 65536 + 50) / 100);
      7'd82: b = 22'(((200 - 2 * 82) * 65536 + 50) / 100);
      7'd83: b = 22'(((200 - 2 * 83) * 65536 + 50) / 100);
      7'd84: b = 22'(((200 - 2 * 84) * 65536 + 50) / 100);
      7'd85: b = 22'(((200 - 2 * 85) * 65536 + 50) / 100);
      7'd86: b = 22'(((200 - 2 * 86) * 65536 + 50) / 100);
      7'd87: b = 22'(((200 - 2 * 87) * 65536 + 50) / 100);
      7'd88: b = 22'(((200 - 2 * 88) * 65536 + 50) / 100);
      7'd89: b = 22'(((200 - 2 * 89) * 65536 + 50) / 100);
      7'd90: b = 22'(((200 - 2 * 90) * 65536 + 50) / 100);
      7'd91: b = 22'(((200 - 2 * 91) * 65536 + 50) / 100);
      7'd92: b = 22'(((200 - 2 * 92) * 65536 + 50) / 100);
      7'd93: b = 22'(((200 - 2 * 93) * 65536 + 50) / 100);
      7'd94: b = 22'(((200 - 2 * 94) * 65536 + 50) / 100);
      7'd95: b = 22'(((200 - 2 * 95) * 65536 + 50) / 100);
      7'd96: b = 22'(((200 - 2 * 96) * 65536 + 50) / 100);
      7'd97: b = 22'(((200 - 2 * 97) * 65536 + 50) / 100);
      7'd98: b = 22'(((200 - 2 * 98) * 65536 + 50) / 100);
      7'd99: b = 22'(((200 - 2 * 99) * 65536 + 50) / 100);
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== src/wavelet_subband_deadzone_quantizer.sv =====
// Top level of the wavelet subband dead-zone quantizer: registers, front, queue, back.
// Depends on wsdq_pkg, wsdq_front, wsdq_fifo and wsdq_back.
//
//   port group  dir  beat contents
//   s_axis_*    in   coefficient, row, column
//   m_axis_*    out  value, subband_level
//   cfg_*       in   register index and data, one write per cycle
//
// One beat is accepted per cycle while the queue is not full; a result passes through the queue,
// the step register, the range-check register, the 16-stage divider and the output register.
// Reset clears the queue, all valid bits and loads the register defaults.
// A stall on the output freezes the back pipeline; the front keeps accepting until the
// four-entry queue is full.
module wavelet_subband_deadzone_quantizer #(
  parameter int MAX_LEVELS    = 8,
  parameter int MAX_DIMENSION = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // coefficient[31:0], row[43:32], column[55:44]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // value[47:0], subband_level[51:48], zeros
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i
);

  wsdq_pkg::cfg_t  cfg_q;
  wsdq_pkg::item_t f_item, q_item;
  logic            q_full, q_valid, q_pop, push;
  logic [47:0]     value;
  logic [3:0]      level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width   <= 13'd512;
      cfg_q.height  <= 13'd512;
      cfg_q.levels  <= 4'd3;
      cfg_q.quality <= 7'd50;
      cfg_q.dir     <= wsdq_pkg::DIR_QUANTIZE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wsdq_pkg::REG_WIDTH:     cfg_q.width   <= cfg_data_i;
        wsdq_pkg::REG_HEIGHT:    cfg_q.height  <= cfg_data_i;
        wsdq_pkg::REG_LEVELS:    cfg_q.levels  <= cfg_data_i[3:0];
        wsdq_pkg::REG_QUALITY:   cfg_q.quality <= cfg_data_i[6:0];
        wsdq_pkg::REG_DIRECTION: cfg_q.dir     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  wsdq_front #(
    .MAX_LEVELS   (MAX_LEVELS),
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .cfg_i        (cfg_q),
    .coefficient_i(s_axis_tdata[31:0]),
    .row_i        (s_axis_tdata[43:32]),
    .column_i     (s_axis_tdata[55:44]),
    .item_o       (f_item)
  );

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  wsdq_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(f_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .rdata_o(q_item)
  );

  wsdq_back #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .item_i     (q_item),
    .pop_o      (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .value_o    (value),
    .level_o    (level)
  );

  assign m_axis_tdata = {4'b0, level, value};

endmodule

// ===== src/wsdq_front.sv =====
// Front part: classifies a coefficient position into its subband and step shift.
// Depends on wsdq_pkg.
module wsdq_front #(
  parameter int MAX_LEVELS    = 8,
  parameter int MAX_DIMENSION = 4096
) (
  input  wsdq_pkg::cfg_t       cfg_i,
  input  logic signed [31:0]   coefficient_i,
  input  logic        [11:0]   row_i,
  input  logic        [11:0]   column_i,
  output wsdq_pkg::item_t      item_o
);

  logic [wsdq_pkg::CFG_DIM_W-1:0] w, h;
  logic [wsdq_pkg::LVL_W-1:0]     lv, cnt, level;
  logic [MAX_LEVELS:0]            in_region;
  logic                           ll, zero;

  always_comb begin
    w = cfg_i.width;
    h = cfg_i.height;
    if (MAX_DIMENSION < 8192 && cfg_i.width > 13'(MAX_DIMENSION)) w = 13'(MAX_DIMENSION);
    if (MAX_DIMENSION < 8192 && cfg_i.height > 13'(MAX_DIMENSION)) h = 13'(MAX_DIMENSION);
    lv = cfg_i.levels;
    if (cfg_i.levels == '0) lv = 4'd1;
    if (cfg_i.levels > 4'(MAX_LEVELS)) lv = 4'(MAX_LEVELS);
    for (int j = 0; j <= MAX_LEVELS; j++) begin
      in_region[j] = ({1'b0, row_i} < (h >> j)) && ({1'b0, column_i} < (w >> j));
    end
    cnt = '0;
    ll  = 1'b0;
    for (int j = 1; j <= MAX_LEVELS; j++) begin
      if (4'(j) < lv && in_region[j]) cnt = cnt + 4'd1;
      if (4'(j) == lv) ll = in_region[j];
    end
    zero  = !in_region[0];
    level = zero ? '0 : (ll ? lv : cnt);
  end

  always_comb begin
    item_o.dir   = cfg_i.dir;
    item_o.zero  = zero;
    item_o.neg   = coefficient_i[31];
    item_o.mag   = coefficient_i[31] ? unsigned'(-coefficient_i) : unsigned'(coefficient_i);
    item_o.shift = lv - level;
    item_o.level = level;
    item_o.base  = wsdq_pkg::quality_step(cfg_i.quality);
  end

endmodule

// ===== src/wsdq_fifo.sv =====
// Short queue of classified items between the front and the back part.
// Depends on wsdq_pkg.
module wsdq_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wsdq_pkg::item_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output wsdq_pkg::item_t rdata_o
);

  wsdq_pkg::item_t mem_q [wsdq_pkg::FIFO_DEPTH];
  logic [wsdq_pkg::FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [wsdq_pkg::FIFO_CNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [wsdq_pkg::FIFO_CNT_W-1:0] FIFO_CNT_ONE(input logic b);
    return {{(wsdq_pkg::FIFO_CNT_W-1){1'b0}}, b};
  endfunction

  assign full_o  = cnt_q == wsdq_pkg::FIFO_CNT_W'(wsdq_pkg::FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + FIFO_CNT_ONE(push_i) - FIFO_CNT_ONE(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= wsdq_pkg::FIFO_CNT_W'(wsdq_pkg::FIFO_DEPTH))
    else $error("queue count exceeds depth");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("push into full queue");
  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not grow on push");
`endif

endmodule

// ===== src/wsdq_back.sv =====
// Back part: step scaling, pipelined restoring divider for quantizing, multiplier for
// dequantizing, and the output register. Depends on wsdq_pkg.
module wsdq_back #(
  parameter int MAX_LEVELS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  wsdq_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [47:0]     value_o,
  output logic [3:0]      level_o
);

  localparam int BASE_W = wsdq_pkg::BASE_W;
  localparam int QUO_W  = wsdq_pkg::QUO_W;
  localparam int STEP_W = BASE_W + MAX_LEVELS;
  localparam int PROD_W = 16 + STEP_W;
  localparam int N_W    = ((41 > STEP_W) ? 41 : STEP_W) + 1;
  localparam int REM_W  = BASE_W + QUO_W;

  typedef struct packed {
    logic              dir;
    logic              zero;
    logic              neg;
    logic              sat;
    logic [3:0]        level;
    logic [BASE_W-1:0] base;
    logic [REM_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
    logic [PROD_W-1:0] prod;
  } stage_t;

  logic adv;
  assign adv   = !out_valid_o || out_ready_i;
  assign pop_o = adv && valid_i;

  // First stage: step, product and the scaled dividend.
  logic [STEP_W-1:0] step;
  logic [15:0]       idx;
  logic [N_W-1:0]    num;
  stage_t            a_d, a_q;
  logic [N_W-1:0]    a_x_d, a_x_q;
  logic              a_v_q;

  always_comb begin
    step = STEP_W'(item_i.base) << item_i.shift;
    if (item_i.neg) idx = (item_i.mag > 32'd32768) ? 16'd32768 : item_i.mag[15:0];
    else            idx = (item_i.mag > 32'd32767) ? 16'd32767 : item_i.mag[15:0];
    num   = N_W'({item_i.mag, 9'b0}) + N_W'(step);
    a_x_d = num >> (item_i.shift + 1'b1);
    a_d.dir   = item_i.dir;
    a_d.zero  = item_i.zero;
    a_d.neg   = item_i.neg;
    a_d.sat   = 1'b0;
    a_d.level = item_i.level;
    a_d.base  = item_i.base;
    a_d.rem   = '0;
    a_d.quo   = '0;
    a_d.prod  = PROD_W'(idx) * PROD_W'(step);
  end

  // Divider chain: s_q[0] is the saturation check stage, one quotient bit per stage after.
  stage_t s_q [QUO_W+1];
  logic   s_v_q [QUO_W+1];
  stage_t b_d;

  always_comb begin
    b_d     = a_q;
    b_d.sat = a_x_q >= N_W'({a_q.base, {QUO_W{1'b0}}});
    b_d.rem = a_x_q[REM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q    <= 1'b0;
      s_v_q[0] <= 1'b0;
    end else if (adv) begin
      a_v_q    <= pop_o;
      s_v_q[0] <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q   <= a_d;
      a_x_q <= a_x_d;
      s_q[0] <= b_d;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic [REM_W-1:0] dv;
    stage_t           nx;
    always_comb begin
      nx = s_q[k];
      dv = REM_W'(s_q[k].base) << (QUO_W - 1 - k);
      if (s_q[k].rem >= dv) begin
        nx.rem = s_q[k].rem - dv;
        nx.quo[QUO_W-1-k] = 1'b1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        s_v_q[k+1] <= s_v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        s_q[k+1] <= nx;
      end
    end
  end

  // Result formation into the output register.
  stage_t              f;
  logic [16:0]         m, lim;
  logic [PROD_W:0]     rnd;
  logic [47:0]         mag48, value_d;
  logic                out_v_q;
  logic [47:0]         value_q;
  logic [3:0]          level_q;

  always_comb begin
    f   = s_q[QUO_W];
    m   = f.sat ? 17'h10000 : {1'b0, f.quo};
    lim = f.neg ? 17'd32768 : 17'd32767;
    if (m > lim) m = lim;
    rnd = (PROD_W+1)'(f.prod) + (PROD_W+1)'(128);
    if (f.dir == wsdq_pkg::DIR_DEQUANTIZE) mag48 = 48'(rnd >> 8);
    else                                   mag48 = 48'(m);
    value_d = f.neg ? (48'd0 - mag48) : mag48;
    if (f.zero) value_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= s_v_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      value_q <= value_d;
      level_q <= f.level;
    end
  end

  assign out_valid_o = out_v_q;
  assign value_o     = value_q;
  assign level_o     = level_q;

endmodule
